// File: design/sme_pkg.sv
// shared types, request codes and letter coding for the subsequence match engine
`default_nettype none
package sme_pkg;

	localparam int CODE_W = 6;

	typedef logic [1:0] req_t;
	localparam req_t REQ_APPEND = 2'd0;
	localparam req_t REQ_QUERY  = 2'd1;
	localparam req_t REQ_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	typedef struct packed {
		logic append;     // store the accepted letter at the end of the text
		logic clear;      // empty the text and drop any open query
		logic skip;       // query letter of an already failed query
		logic scan_start; // load a query letter and set up the scan
		logic scan;       // scan in progress
	} cmd_t;

	typedef struct packed {
		logic scan_done;  // hit found or text exhausted
		logic in_query;
		logic failed;
	} sts_t;

	// lowercase to 0..25, everything else (symbol - 'A' + 26) mod 64
	function automatic logic [CODE_W-1:0] letter_code(input logic [6:0] sym);
		logic [6:0] t;
		begin
			if (sym >= 7'd97 && sym <= 7'd122) begin
				t = sym - 7'd97;
			end else begin
				t = sym - 7'd39;
			end
			return t[CODE_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// File: design/sme_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module sme_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: design/sme_ctrl.sv
// controller state machine for the subsequence match engine
`default_nettype none
module sme_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    req_type,
	input  wire sme_pkg::sts_t sts,
	output      logic          busy,
	output      sme_pkg::cmd_t cmd
);
	import sme_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q == ST_SCAN);
	assign accept = start && !busy;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (req_type == REQ_APPEND) begin
						cmd.append = 1'b1;
					end else if (req_type == REQ_CLEAR) begin
						cmd.clear = 1'b1;
					end else if (req_type == REQ_QUERY) begin
						if (sts.in_query && sts.failed) begin
							cmd.skip = 1'b1;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = ST_SCAN;
						end
					end else begin
						cmd = '0;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: design/sme_dp.sv
// datapath: text memory, length, query registers, scan pointer and result registers
`default_nettype none
module sme_dp #(
	parameter int TEXT_MAX = 65536
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sme_pkg::cmd_t cmd,
	input  wire logic [6:0]    symbol,
	input  wire logic          last,
	output      sme_pkg::sts_t sts,
	output      logic          done,
	output      logic          matched,
	output      logic [15:0]   first_pos,
	output      logic [15:0]   last_pos
);
	import sme_pkg::*;

	localparam int AW = $clog2(TEXT_MAX);
	localparam logic [AW:0] LEN_FULL = (AW+1)'(TEXT_MAX);

	logic [AW:0]       len_q;
	logic              in_query_q, failed_q;
	logic [AW-1:0]     cursor_q, first_q;
	logic [CODE_W-1:0] code_q;
	logic              last_q;
	logic [AW:0]       scan_q;
	logic              pend_v_q;
	logic [AW-1:0]     pend_addr_q;
	logic              done_q, matched_q;
	logic [15:0]       first_pos_q, last_pos_q;

	logic [CODE_W-1:0] rd_data;
	logic              wr_en, hit, more, issue, scan_done;

	assign wr_en     = cmd.append && (len_q != LEN_FULL);
	assign hit       = pend_v_q && (rd_data == code_q);
	assign more      = (scan_q < len_q);
	assign issue     = !hit && more;
	assign scan_done = hit || (!pend_v_q && !more);

	sme_ram #(
		.WIDTH(CODE_W),
		.DEPTH(TEXT_MAX)
	) u_text (
		.clk  (clk),
		.we   (wr_en),
		.waddr(len_q[AW-1:0]),
		.wdata(letter_code(symbol)),
		.raddr(scan_q[AW-1:0]),
		.rdata(rd_data)
	);

	// scan registers and query letter payload
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			code_q   <= letter_code(symbol);
			last_q   <= last;
			scan_q   <= in_query_q ? ({1'b0, cursor_q} + 1'b1) : '0;
		end else if (cmd.scan) begin
			pend_addr_q <= scan_q[AW-1:0];
			if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.skip) begin
			matched_q   <= 1'b0;
			first_pos_q <= '0;
			last_pos_q  <= '0;
		end else if (cmd.scan && scan_done) begin
			matched_q   <= hit;
			first_pos_q <= hit ? (in_query_q ? 16'(first_q) : 16'(pend_addr_q)) : '0;
			last_pos_q  <= hit ? 16'(pend_addr_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			in_query_q <= 1'b0;
			failed_q   <= 1'b0;
			cursor_q   <= '0;
			first_q    <= '0;
			pend_v_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.append && wr_en) begin
				len_q <= len_q + 1'b1;
			end
			if (cmd.clear) begin
				len_q      <= '0;
				in_query_q <= 1'b0;
				failed_q   <= 1'b0;
				cursor_q   <= '0;
				first_q    <= '0;
			end
			if (cmd.skip && last) begin
				done_q     <= 1'b1;
				in_query_q <= 1'b0;
				failed_q   <= 1'b0;
				cursor_q   <= '0;
				first_q    <= '0;
			end
			if (cmd.scan_start) begin
				pend_v_q <= 1'b0;
			end else if (cmd.scan) begin
				pend_v_q <= issue;
				if (scan_done) begin
					if (last_q) begin
						done_q     <= 1'b1;
						in_query_q <= 1'b0;
						failed_q   <= 1'b0;
						cursor_q   <= '0;
						first_q    <= '0;
					end else begin
						in_query_q <= 1'b1;
						failed_q   <= !hit;
						if (!in_query_q) begin
							first_q  <= hit ? pend_addr_q : '0;
							cursor_q <= hit ? pend_addr_q : '0;
						end else if (hit) begin
							cursor_q <= pend_addr_q;
						end
					end
				end
			end
		end
	end

	assign sts.scan_done = scan_done;
	assign sts.in_query  = in_query_q;
	assign sts.failed    = failed_q;

	assign done      = done_q;
	assign matched   = matched_q;
	assign first_pos = first_pos_q;
	assign last_pos  = last_pos_q;

endmodule
`default_nettype wire

// File: design/subsequence_match_engine_unit.sv
// top level of the subsequence match engine: controller plus datapath
// append, clear and letters of an already failed query are taken in idle; busy stays low
// a query letter holds busy while the scan reads the text, until a hit or nothing is left to read
// the result strobe (done) comes in the cycle after the final letter's scan ends or it is skipped
// arst_n clears length, query state and control; stored text is undefined until appended
`default_nettype none
module subsequence_match_engine_unit #(
	parameter int TEXT_MAX = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [6:0]  symbol,
	input  wire logic        last,
	output      logic        done,
	output      logic        matched,
	output      logic [15:0] first_pos,
	output      logic [15:0] last_pos
);
	import sme_pkg::*;

	// command and status between the two halves
	cmd_t cmd;
	sts_t sts;

	// controller: idle takes items, scan walks the text one position per cycle
	sme_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req_type),
		.sts     (sts),
		.busy    (busy),
		.cmd     (cmd)
	);

	// datapath: text ram, greedy match registers and the result register
	sme_dp #(
		.TEXT_MAX(TEXT_MAX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.symbol   (symbol),
		.last     (last),
		.sts      (sts),
		.done     (done),
		.matched  (matched),
		.first_pos(first_pos),
		.last_pos (last_pos)
	);

endmodule
`default_nettype wire
